@@ hw/rtl/spc_pkg.sv @@
package spc_pkg;

	localparam int IdxW      = 16;
	localparam int CoordW    = 32;
	localparam int RadW      = 24;
	localparam int MagW      = 25;
	localparam int SqW       = 50;
	localparam int SumW      = 52;
	localparam int DistW     = 25;
	localparam int RemW      = 28;
	localparam int SqrtSteps = 25;
	localparam int DivSteps  = 25;
	localparam int NormQW    = 15;
	localparam int OffQW     = 25;
	localparam int NumW      = 52;
	localparam int NormW     = 16;

	typedef struct packed {
		logic [IdxW-1:0]            idx_a;
		logic [IdxW-1:0]            idx_b;
		logic [2:0]                 neg;
		logic [2:0][MagW-1:0]       mag;
		logic [2:0][CoordW-1:0]     pos;
		logic [RadW-1:0]            ra;
		logic [DistW-1:0]           rsum;
	} ctx_t;

	typedef struct packed {
		logic [IdxW-1:0]            idx_a;
		logic [IdxW-1:0]            idx_b;
		logic [2:0]                 neg_n;
		logic [2:0]                 neg_o;
		logic [2:0][CoordW-1:0]     pos;
		logic [DistW-1:0]           ov;
	} post_t;

	typedef struct packed {
		logic [RemW-1:0]  rem;
		logic [DistW-1:0] root;
	} sq_step_t;

	typedef struct packed {
		logic [NumW-1:0] rem;
		logic            bit_set;
	} div_step_t;

	function automatic sq_step_t sqrt_step(input logic [RemW-1:0] rem,
		input logic [DistW-1:0] root, input logic [1:0] pair);
		logic [RemW+1:0] acc;
		logic [RemW+1:0] trial;
		sq_step_t        r;
		acc   = {rem, pair};
		trial = {3'b000, root, 2'b01};
		if (acc >= trial) begin
			r.rem  = RemW'(acc - trial);
			r.root = {root[DistW-2:0], 1'b1};
		end else begin
			r.rem  = acc[RemW-1:0];
			r.root = {root[DistW-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic div_step_t div_step(input logic [NumW-1:0] rem,
		input logic [NumW-1:0] den_sh);
		div_step_t r;
		if (rem >= den_sh) begin
			r.rem     = rem - den_sh;
			r.bit_set = 1'b1;
		end else begin
			r.rem     = rem;
			r.bit_set = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/spc_sqrt.sv @@
module spc_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [spc_pkg::SqW-1:0]      in_v,
	input  spc_pkg::ctx_t                in_ctx,
	output logic                         out_vld,
	output logic [spc_pkg::DistW-1:0]    out_dist,
	output spc_pkg::ctx_t                out_ctx
);

	localparam int N = spc_pkg::SqrtSteps;

	logic [N-1:0]                 vld_s;
	logic [spc_pkg::RemW-1:0]     rem_s  [N];
	logic [spc_pkg::DistW-1:0]    root_s [N];
	logic [spc_pkg::SqW-1:0]      v_s    [N];
	spc_pkg::ctx_t                ctx_s  [N];

	for (genvar j = 0; j < N; j++) begin : g_step
		logic                      vld_in;
		logic [spc_pkg::RemW-1:0]  rem_in;
		logic [spc_pkg::DistW-1:0] root_in;
		logic [spc_pkg::SqW-1:0]   v_in;
		spc_pkg::ctx_t             ctx_in;
		spc_pkg::sq_step_t         res;

		if (j == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = '0;
			assign root_in = '0;
			assign v_in    = in_v;
			assign ctx_in  = in_ctx;
		end else begin : g_next
			assign vld_in  = vld_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign v_in    = v_s[j-1];
			assign ctx_in  = ctx_s[j-1];
		end

		assign res = spc_pkg::sqrt_step(rem_in, root_in, v_in[2*(N-1-j) +: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j]  <= res.rem;
			root_s[j] <= res.root;
			v_s[j]    <= v_in;
			ctx_s[j]  <= ctx_in;
		end
	end

	assign out_vld  = vld_s[N-1];
	assign out_dist = root_s[N-1];
	assign out_ctx  = ctx_s[N-1];

endmodule

@@ hw/rtl/spc_div.sv @@
module spc_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  logic [spc_pkg::DistW-1:0]         in_den,
	input  logic [2:0][spc_pkg::NumW-1:0]     in_num_n,
	input  logic [2:0][spc_pkg::NumW-1:0]     in_num_o,
	input  spc_pkg::post_t                    in_post,
	output logic                              out_vld,
	output logic [2:0][spc_pkg::NormQW-1:0]   out_q_n,
	output logic [2:0][spc_pkg::OffQW-1:0]    out_q_o,
	output spc_pkg::post_t                    out_post
);

	localparam int N = spc_pkg::DivSteps;
	localparam int W = spc_pkg::NumW;

	logic [N-1:0]                      vld_s;
	logic [spc_pkg::DistW-1:0]         den_s   [N];
	logic [2:0][W-1:0]                 rem_n_s [N];
	logic [2:0][W-1:0]                 rem_o_s [N];
	logic [2:0][spc_pkg::NormQW-1:0]   q_n_s   [N];
	logic [2:0][spc_pkg::OffQW-1:0]    q_o_s   [N];
	spc_pkg::post_t                    post_s  [N];

	for (genvar j = 0; j < N; j++) begin : g_step
		localparam int K = N - 1 - j;
		logic                              vld_in;
		logic [spc_pkg::DistW-1:0]         den_in;
		logic [2:0][W-1:0]                 rem_n_in;
		logic [2:0][W-1:0]                 rem_o_in;
		logic [2:0][spc_pkg::NormQW-1:0]   q_n_in;
		logic [2:0][spc_pkg::OffQW-1:0]    q_o_in;
		spc_pkg::post_t                    post_in;
		logic [2:0][W-1:0]                 rem_n_nx;
		logic [2:0][W-1:0]                 rem_o_nx;
		logic [2:0][spc_pkg::NormQW-1:0]   q_n_nx;
		logic [2:0][spc_pkg::OffQW-1:0]    q_o_nx;
		logic [W-1:0]                      sh_o;
		spc_pkg::div_step_t                r_o [3];

		if (j == 0) begin : g_first
			assign vld_in   = in_vld;
			assign den_in   = in_den;
			assign rem_n_in = in_num_n;
			assign rem_o_in = in_num_o;
			assign q_n_in   = '0;
			assign q_o_in   = '0;
			assign post_in  = in_post;
		end else begin : g_next
			assign vld_in   = vld_s[j-1];
			assign den_in   = den_s[j-1];
			assign rem_n_in = rem_n_s[j-1];
			assign rem_o_in = rem_o_s[j-1];
			assign q_n_in   = q_n_s[j-1];
			assign q_o_in   = q_o_s[j-1];
			assign post_in  = post_s[j-1];
		end

		assign sh_o = {{(W-spc_pkg::DistW-1){1'b0}}, den_in, 1'b0} << K;

		for (genvar a = 0; a < 3; a++) begin : g_axis
			assign r_o[a] = spc_pkg::div_step(rem_o_in[a], sh_o);

			always_comb begin
				q_o_nx[a]    = q_o_in[a];
				q_o_nx[a][K] = r_o[a].bit_set;
				rem_o_nx[a]  = r_o[a].rem;
			end

			if (K < spc_pkg::NormQW) begin : g_norm
				logic [W-1:0]       sh_n;
				spc_pkg::div_step_t r_n;
				assign sh_n = {{(W-spc_pkg::DistW){1'b0}}, den_in} << K;
				assign r_n  = spc_pkg::div_step(rem_n_in[a], sh_n);
				always_comb begin
					q_n_nx[a]    = q_n_in[a];
					q_n_nx[a][K] = r_n.bit_set;
					rem_n_nx[a]  = r_n.rem;
				end
			end else begin : g_hold
				assign q_n_nx[a]   = q_n_in[a];
				assign rem_n_nx[a] = rem_n_in[a];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			den_s[j]   <= den_in;
			rem_n_s[j] <= rem_n_nx;
			rem_o_s[j] <= rem_o_nx;
			q_n_s[j]   <= q_n_nx;
			q_o_s[j]   <= q_o_nx;
			post_s[j]  <= post_in;
		end
	end

	assign out_vld  = vld_s[N-1];
	assign out_q_n  = q_n_s[N-1];
	assign out_q_o  = q_o_s[N-1];
	assign out_post = post_s[N-1];

endmodule

@@ hw/rtl/sphere_pair_contact.sv @@
// Sphere pair contact test. A pair is taken on every clock edge at which start is
// high; busy is always low, so one pair per cycle is sustained. The result of a pair
// appears, if the spheres touch, with done high for one cycle. The pair passes through
// the 25-stage square root (one root bit per stage) followed by the 25-stage divider
// that forms the normal and the contact point offset. Pairs that do not touch, or that
// have an inactive sphere or coincident centres, produce no beat. The receiver
// cannot stall, so every done beat must be taken when it appears.
module sphere_pair_contact (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [spc_pkg::IdxW-1:0]           first_index,
	input  logic [spc_pkg::IdxW-1:0]           second_index,
	input  logic                               first_active,
	input  logic                               second_active,
	input  logic signed [spc_pkg::CoordW-1:0]  first_x,
	input  logic signed [spc_pkg::CoordW-1:0]  first_y,
	input  logic signed [spc_pkg::CoordW-1:0]  first_z,
	input  logic signed [spc_pkg::CoordW-1:0]  second_x,
	input  logic signed [spc_pkg::CoordW-1:0]  second_y,
	input  logic signed [spc_pkg::CoordW-1:0]  second_z,
	input  logic [spc_pkg::RadW-1:0]           first_radius,
	input  logic [spc_pkg::RadW-1:0]           second_radius,
	output logic                               done,
	output logic [spc_pkg::IdxW-1:0]           contact_first,
	output logic [spc_pkg::IdxW-1:0]           contact_second,
	output logic signed [spc_pkg::NormW-1:0]   normal_x,
	output logic signed [spc_pkg::NormW-1:0]   normal_y,
	output logic signed [spc_pkg::NormW-1:0]   normal_z,
	output logic [spc_pkg::DistW-1:0]          overlap_depth,
	output logic signed [spc_pkg::CoordW-1:0]  point_x,
	output logic signed [spc_pkg::CoordW-1:0]  point_y,
	output logic signed [spc_pkg::CoordW-1:0]  point_z
);

	localparam int CW = spc_pkg::CoordW;
	localparam int MW = spc_pkg::MagW;
	localparam int DW = spc_pkg::DistW;
	localparam int NW = spc_pkg::NumW;

	assign busy = 1'b0;

	logic signed [CW-1:0] pa [3];
	logic signed [CW-1:0] pb [3];
	assign pa[0] = first_x;
	assign pa[1] = first_y;
	assign pa[2] = first_z;
	assign pb[0] = second_x;
	assign pb[1] = second_y;
	assign pb[2] = second_z;

	// Stage 1: centre difference, magnitudes and far test.
	logic                  vld_s1;
	logic                  kill_s1;
	spc_pkg::ctx_t         ctx_s1;
	logic [2:0]            far_c;
	spc_pkg::ctx_t         ctx_c;

	always_comb begin
		ctx_c.idx_a = first_index;
		ctx_c.idx_b = second_index;
		ctx_c.ra    = first_radius;
		ctx_c.rsum  = {1'b0, first_radius} + {1'b0, second_radius};
		for (int a = 0; a < 3; a++) begin
			logic signed [CW:0] d;
			logic [CW:0]        m;
			d = {pb[a][CW-1], pb[a]} - {pa[a][CW-1], pa[a]};
			m = d[CW] ? (CW+1)'(-d) : d;
			ctx_c.neg[a] = d[CW];
			ctx_c.mag[a] = m[MW-1:0];
			ctx_c.pos[a] = pa[a];
			far_c[a]     = |m[CW:MW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s1  <= ctx_c;
		kill_s1 <= ~(first_active & second_active) | (|far_c);
	end

	// Stage 2: squares.
	logic                    vld_s2;
	logic                    kill_s2;
	spc_pkg::ctx_t           ctx_s2;
	logic [spc_pkg::SqW-1:0] sq_s2 [3];
	logic [spc_pkg::SqW-1:0] rsq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		kill_s2 <= kill_s1;
		ctx_s2  <= ctx_s1;
		rsq_s2  <= ctx_s1.rsum * ctx_s1.rsum;
		for (int a = 0; a < 3; a++) begin
			sq_s2[a] <= ctx_s1.mag[a] * ctx_s1.mag[a];
		end
	end

	// Stage 3: squared distance and hit decision.
	logic                     hit_s3;
	spc_pkg::ctx_t            ctx_s3;
	logic [spc_pkg::SqW-1:0]  v_s3;
	logic [spc_pkg::SumW-1:0] s_c;

	assign s_c = {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s3 <= 1'b0;
		end else begin
			hit_s3 <= vld_s2 & ~kill_s2 & (s_c != '0) & ({2'b00, rsq_s2} > s_c);
		end
	end

	always_ff @(posedge clk) begin
		ctx_s3 <= ctx_s2;
		v_s3   <= s_c[spc_pkg::SqW-1:0];
	end

	logic               sq_vld;
	logic [DW-1:0]      sq_dist;
	spc_pkg::ctx_t      sq_ctx;

	spc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (hit_s3),
		.in_v     (v_s3),
		.in_ctx   (ctx_s3),
		.out_vld  (sq_vld),
		.out_dist (sq_dist),
		.out_ctx  (sq_ctx)
	);

	// Stage 4: overlap and point lever.
	logic               vld_s4;
	spc_pkg::ctx_t      ctx_s4;
	logic [DW-1:0]      dist_s4;
	logic [DW-1:0]      ov_s4;
	logic [DW:0]        tmag_s4;
	logic               tneg_s4;
	logic [DW-1:0]      ov_c;
	logic signed [DW+1:0] t_c;

	assign ov_c = sq_ctx.rsum - sq_dist;
	assign t_c  = $signed({2'b00, sq_ctx.ra, 1'b0}) - $signed({2'b00, ov_c});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s4  <= sq_ctx;
		dist_s4 <= sq_dist;
		ov_s4   <= ov_c;
		tneg_s4 <= t_c[DW+1];
		tmag_s4 <= t_c[DW+1] ? (DW+1)'(-t_c) : t_c[DW:0];
	end

	// Stage 5: lever products.
	logic               vld_s5;
	spc_pkg::ctx_t      ctx_s5;
	logic [DW-1:0]      dist_s5;
	logic [DW-1:0]      ov_s5;
	logic               tneg_s5;
	logic [NW-1:0]      prod_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s5  <= ctx_s4;
		dist_s5 <= dist_s4;
		ov_s5   <= ov_s4;
		tneg_s5 <= tneg_s4;
		for (int a = 0; a < 3; a++) begin
			prod_s5[a] <= {{(NW-MW){1'b0}}, ctx_s4.mag[a]}
				* {{(NW-DW-1){1'b0}}, tmag_s4};
		end
	end

	// Stage 6: rounded numerators.
	logic                       vld_s6;
	logic [DW-1:0]              dist_s6;
	logic [2:0][NW-1:0]         num_n_s6;
	logic [2:0][NW-1:0]         num_o_s6;
	spc_pkg::post_t             post_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		dist_s6       <= dist_s5;
		post_s6.idx_a <= ctx_s5.idx_a;
		post_s6.idx_b <= ctx_s5.idx_b;
		post_s6.ov    <= ov_s5;
		for (int a = 0; a < 3; a++) begin
			num_n_s6[a]      <= {{(NW-MW-14){1'b0}}, ctx_s5.mag[a], 14'd0}
				+ {{(NW-DW+1){1'b0}}, dist_s5[DW-1:1]};
			num_o_s6[a]      <= prod_s5[a] + {{(NW-DW){1'b0}}, dist_s5};
			post_s6.neg_n[a] <= ctx_s5.neg[a];
			post_s6.neg_o[a] <= ctx_s5.neg[a] ^ tneg_s5;
			post_s6.pos[a]   <= ctx_s5.pos[a];
		end
	end

	logic                                 dv_vld;
	logic [2:0][spc_pkg::NormQW-1:0]      dv_q_n;
	logic [2:0][spc_pkg::OffQW-1:0]       dv_q_o;
	spc_pkg::post_t                       dv_post;

	spc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s6),
		.in_den   (dist_s6),
		.in_num_n (num_n_s6),
		.in_num_o (num_o_s6),
		.in_post  (post_s6),
		.out_vld  (dv_vld),
		.out_q_n  (dv_q_n),
		.out_q_o  (dv_q_o),
		.out_post (dv_post)
	);

	// Output stage: signs and saturated contact point.
	logic signed [spc_pkg::NormW-1:0] n_c [3];
	logic signed [CW-1:0]             p_c [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic signed [spc_pkg::NormW-1:0] nq;
			logic signed [CW+1:0]             oq;
			logic signed [CW+1:0]             sum;
			nq = $signed({1'b0, dv_q_n[a]});
			oq = $signed({{(CW+2-spc_pkg::OffQW){1'b0}}, dv_q_o[a]});
			n_c[a] = dv_post.neg_n[a] ? -nq : nq;
			sum = $signed({{2{dv_post.pos[a][CW-1]}}, dv_post.pos[a]})
				+ (dv_post.neg_o[a] ? -oq : oq);
			if (sum > $signed({3'b000, {(CW-1){1'b1}}})) begin
				p_c[a] = {1'b0, {(CW-1){1'b1}}};
			end else if (sum < $signed({3'b111, {(CW-1){1'b0}}})) begin
				p_c[a] = {1'b1, {(CW-1){1'b0}}};
			end else begin
				p_c[a] = sum[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		contact_first  <= dv_post.idx_a;
		contact_second <= dv_post.idx_b;
		overlap_depth  <= dv_post.ov;
		normal_x       <= n_c[0];
		normal_y       <= n_c[1];
		normal_z       <= n_c[2];
		point_x        <= p_c[0];
		point_y        <= p_c[1];
		point_z        <= p_c[2];
	end

`ifndef ASSERT_OFF
	a_overlap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> overlap_depth != '0)
		else $error("contact beat with zero overlap");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
			normal_y <= 16'sd16384 && normal_y >= -16'sd16384 &&
			normal_z <= 16'sd16384 && normal_z >= -16'sd16384))
		else $error("normal component out of range");

	a_normal_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(normal_x == '0 && normal_y == '0 && normal_z == '0))
		else $error("contact beat with zero normal");

	a_hit_follows_valid: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s3 |-> $past(vld_s2))
		else $error("hit without a pair in flight");
`endif

endmodule
